>>> rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg: shared types and constants for the point rotation pipeline
// Coordinate and angle formats, CORDIC arctangent table, stage payloads.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Field widths
  localparam int COORD_W = 32;
  localparam int ANG_W   = 16;

  // CORDIC depth and guard fraction bits below the coordinate LSB
  localparam int CORDIC_STAGES = 24;
  localparam int FRAC_BITS     = 16;

  // Offset and gain prescale: K = GAIN_INV / 2^31
  localparam int DIFF_W    = COORD_W + 1;
  localparam int K_W       = 31;
  localparam logic [K_W-1:0] GAIN_INV = K_W'(1304065748);
  localparam int LO_W      = 16;
  localparam int HI_W      = DIFF_W - LO_W;
  localparam int PL_W      = LO_W + K_W;
  localparam int PH_W      = HI_W + K_W;
  localparam int PROD_W    = DIFF_W + K_W;
  localparam int PRE_SHIFT = K_W - FRAC_BITS;

  // Rotator word: offset, guard bits and headroom for the CORDIC gain
  localparam int X_W = DIFF_W + FRAC_BITS + 3;

  // Binary angle: 2^ANG_BITS is one full turn
  localparam int ANG_BITS = 32;
  localparam int Z_W      = ANG_BITS + 2;
  localparam int ANG_QTR  = 2 ** (ANG_BITS - 2);

  // Degree conversion: full turn = 23040 = 45 * 2^9 units of 1/64 degree
  localparam int ANG_TURN = 23040;
  localparam int ANG_POW2 = 9;
  localparam int ANG_ODD  = ANG_TURN / (2 ** ANG_POW2);
  localparam int R_W      = 15;
  localparam int ANG_Q    = (2 ** (ANG_BITS - ANG_POW2)) / ANG_ODD;
  localparam int ANG_REM  = (2 ** (ANG_BITS - ANG_POW2)) - ANG_Q * ANG_ODD;
  localparam int ANG_HALF = (ANG_TURN / 2) / (2 ** ANG_POW2);
  localparam int QR_W     = ANG_BITS + 1;
  localparam int V_W      = 20;
  localparam int DIV_S    = 26;
  localparam int DIV_M    = (2 ** DIV_S) / ANG_ODD + 1;
  localparam int M_W      = 21;
  localparam int T_W      = V_W + M_W;

  // Final rounding and saturation
  localparam int SUM_W = X_W - FRAC_BITS + 1;

  // atan(2^-i) in binary-angle units
  localparam logic [ANG_BITS-1:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Input item
  typedef struct packed {
    logic signed [COORD_W-1:0] base_x;
    logic signed [COORD_W-1:0] base_y;
    logic signed [COORD_W-1:0] base_z;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [ANG_W-1:0]   angle_deg;
  } point_t;

  // Values carried alongside the rotator
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] bz;
  } side_t;

  // Rotator state between stages
  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
    side_t                 side;
  } vec_t;

  // Result item
  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      overflow;
  } res_t;

endpackage

>>> rtl/prc_in_if.sv
// ----------------------------------------------------------------------------
// prc_in_if: point item channel
// Valid/ready channel carrying the point, the center and the angle.
// ----------------------------------------------------------------------------
interface prc_in_if;
  import prc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] base_x;
  logic signed [COORD_W-1:0] base_y;
  logic signed [COORD_W-1:0] base_z;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [ANG_W-1:0]   angle_deg;

  modport source (
    output valid, base_x, base_y, base_z, center_x, center_y, angle_deg,
    input  ready
  );

  modport sink (
    input  valid, base_x, base_y, base_z, center_x, center_y, angle_deg,
    output ready
  );

endinterface

>>> rtl/prc_out_if.sv
// ----------------------------------------------------------------------------
// prc_out_if: rotated point item channel
// Valid/ready channel carrying the rotated point and the overflow flag.
// ----------------------------------------------------------------------------
interface prc_out_if;
  import prc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic                      overflow;

  modport source (
    output valid, out_x, out_y, out_z, overflow,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, overflow,
    output ready
  );

endinterface

>>> rtl/point_rotate_about_center_unit.sv
// ----------------------------------------------------------------------------
// point_rotate_about_center_unit: rotate a point about a center in XY
// Pipelined angle conversion, gain-compensated CORDIC and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   points carries one item per valid/ready handshake: base_x/y/z and
//   center_x/y in signed Q16.16 and angle_deg in 1/64 degree (CCW positive).
//   results returns one item for each input, in order: out_x/out_y rotated
//   and saturated, out_z equal to base_z, overflow set when x or y clamped.
//   The pipeline has five front-end stages, one stage per CORDIC
//   micro-rotation and two output stages.
//   Throughput is one item per cycle while results is ready; every stage
//   holds one item and the depth of the CORDIC chain sets the latency.
//   When results is stalled, items keep moving into empty stages, so points
//   stays ready until the pipeline is full; a full pipeline holds its items
//   and drops ready on points. Nothing is lost or repeated.
//   Reset (rst, synchronous) empties the pipeline; data is not reset.
// ----------------------------------------------------------------------------
module point_rotate_about_center_unit (
  input  logic       clk,
  input  logic       rst,
  prc_in_if.sink     points,
  prc_out_if.source  results
);
  import prc_pkg::*;

  point_t pin;
  vec_t   prep_data, cordic_data;
  logic   prep_valid, prep_ready;
  logic   cordic_valid, cordic_ready;
  res_t   res;

  // Gather the input fields
  assign pin.base_x    = points.base_x;
  assign pin.base_y    = points.base_y;
  assign pin.base_z    = points.base_z;
  assign pin.center_x  = points.center_x;
  assign pin.center_y  = points.center_y;
  assign pin.angle_deg = points.angle_deg;

  prc_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (points.valid),
    .in_ready  (points.ready),
    .in_data   (pin),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_data  (prep_data)
  );

  prc_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (cordic_valid),
    .out_ready (cordic_ready),
    .out_data  (cordic_data)
  );

  prc_post u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cordic_valid),
    .in_ready  (cordic_ready),
    .in_data   (cordic_data),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (res)
  );

  // Drive the result fields
  assign results.out_x    = res.out_x;
  assign results.out_y    = res.out_y;
  assign results.out_z    = res.out_z;
  assign results.overflow = res.overflow;

endmodule

>>> rtl/prc_prep.sv
// ----------------------------------------------------------------------------
// prc_prep: front end of the rotation pipeline
// Five stages: angle reduction and offsets, gain prescale products,
// product rounding, binary angle conversion, quadrant pre-rotation.
// ----------------------------------------------------------------------------
module prc_prep (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  prc_pkg::point_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output prc_pkg::vec_t  out_data
);
  import prc_pkg::*;

  localparam logic signed [ANG_W:0]  TURN_S  = (ANG_W + 1)'(ANG_TURN);
  localparam logic signed [ANG_W:0]  TURN2_S = (ANG_W + 1)'(2 * ANG_TURN);
  localparam logic signed [PROD_W:0] PRE_RND = (PROD_W + 1)'(2 ** (PRE_SHIFT - 1));
  localparam logic signed [Z_W-1:0]  QTR_Z   = Z_W'(ANG_QTR);

  // Stage valid bits and per-stage advance
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // Stage 1
  logic [R_W-1:0]           r1;
  logic signed [DIFF_W-1:0] dx_x1, dx_y1;
  side_t                    side1;
  // Stage 2
  logic [PL_W-1:0]          pl_x2, pl_y2;
  logic signed [PH_W-1:0]   ph_x2, ph_y2;
  logic [QR_W-1:0]          qr2;
  logic [V_W-1:0]           v2_num;
  side_t                    side2;
  // Stage 3
  logic signed [X_W-1:0]    x3, y3;
  logic [QR_W-1:0]          qr3;
  logic [T_W-1:0]           t3;
  side_t                    side3;
  // Stage 4
  logic signed [X_W-1:0]    x4, y4;
  logic signed [Z_W-1:0]    z4;
  side_t                    side4;
  // Stage 5
  vec_t                     vec5;

  logic signed [ANG_W:0]    a_ext;
  logic signed [ANG_W:0]    a_red;
  logic [QR_W-1:0]          p_full;
  vec_t                     rot;

  // Combine the two partial products, round and drop the prescale fraction
  function automatic logic signed [X_W-1:0] scale_sum(
    input logic signed [PH_W-1:0] ph,
    input logic [PL_W-1:0]        pl
  );
    logic signed [PROD_W:0] acc;
    acc = ((PROD_W + 1)'(ph) <<< LO_W) + $signed((PROD_W + 1)'(pl)) + PRE_RND;
    return X_W'(acc >>> PRE_SHIFT);
  endfunction

  // Advance a stage when it is empty or its successor advances
  assign rdy5     = !v5 || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Reduce the angle into one turn
  always_comb begin
    a_ext = (ANG_W + 1)'(in_data.angle_deg);
    if (a_ext >= TURN_S) begin
      a_red = a_ext - TURN_S;
    end else if (a_ext >= 0) begin
      a_red = a_ext;
    end else if (a_ext >= -TURN_S) begin
      a_red = a_ext + TURN_S;
    end else begin
      a_red = a_ext + TURN2_S;
    end
  end

  // Binary angle: integer part plus the reciprocal-multiplied remainder term
  assign p_full = qr3 + QR_W'(t3 >> DIV_S);

  // Pre-rotate by a quarter turn when the angle lies beyond +-90 degrees
  always_comb begin
    rot.side = side4;
    rot.x    = x4;
    rot.y    = y4;
    rot.z    = z4;
    if (z4 > QTR_Z) begin
      rot.x = -y4;
      rot.y = x4;
      rot.z = z4 - QTR_Z;
    end else if (z4 < -QTR_Z) begin
      rot.x = y4;
      rot.y = -x4;
      rot.z = z4 + QTR_Z;
    end
  end

  // Move valid bits along the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // Stage data registers
  always_ff @(posedge clk) begin
    if (rdy1) begin
      r1       <= a_red[R_W-1:0];
      dx_x1    <= DIFF_W'(in_data.base_x) - DIFF_W'(in_data.center_x);
      dx_y1    <= DIFF_W'(in_data.base_y) - DIFF_W'(in_data.center_y);
      side1.cx <= in_data.center_x;
      side1.cy <= in_data.center_y;
      side1.bz <= in_data.base_z;
    end
    if (rdy2) begin
      pl_x2  <= PL_W'(dx_x1[LO_W-1:0]) * PL_W'(GAIN_INV);
      pl_y2  <= PL_W'(dx_y1[LO_W-1:0]) * PL_W'(GAIN_INV);
      ph_x2  <= $signed(dx_x1[DIFF_W-1:LO_W]) * $signed({1'b0, GAIN_INV});
      ph_y2  <= $signed(dx_y1[DIFF_W-1:LO_W]) * $signed({1'b0, GAIN_INV});
      qr2    <= QR_W'(r1) * QR_W'(ANG_Q);
      v2_num <= V_W'(r1) * V_W'(ANG_REM) + V_W'(ANG_HALF);
      side2  <= side1;
    end
    if (rdy3) begin
      x3    <= scale_sum(ph_x2, pl_x2);
      y3    <= scale_sum(ph_y2, pl_y2);
      qr3   <= qr2;
      t3    <= T_W'(v2_num) * T_W'(DIV_M);
      side3 <= side2;
    end
    if (rdy4) begin
      x4    <= x3;
      y4    <= y3;
      z4    <= Z_W'($signed(p_full[ANG_BITS-1:0]));
      side4 <= side3;
    end
    if (rdy5) begin
      vec5 <= rot;
    end
  end

  assign out_valid = v5;
  assign out_data  = vec5;

  // Reduced angle stays within one turn
  a_red_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (r1 < R_W'(ANG_TURN)))
    else $error("reduced angle outside one turn");

  // Pre-rotation leaves at most a quarter turn for the CORDIC
  a_quadrant: assert property (@(posedge clk) disable iff (rst)
    v5 |-> ((vec5.z <= QTR_Z) && (vec5.z >= -QTR_Z)))
    else $error("residual angle beyond a quarter turn");

endmodule

>>> rtl/prc_cordic.sv
// ----------------------------------------------------------------------------
// prc_cordic: unrolled CORDIC rotator
// One micro-rotation per register stage, CORDIC_STAGES stages deep.
// ----------------------------------------------------------------------------
module prc_cordic (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  prc_pkg::vec_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output prc_pkg::vec_t out_data
);
  import prc_pkg::*;

  vec_t stg [CORDIC_STAGES];
  logic vld [CORDIC_STAGES];
  logic rdy [CORDIC_STAGES + 1];

  assign rdy[CORDIC_STAGES] = out_ready;
  assign in_ready           = rdy[0];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    vec_t                  src;
    logic                  src_v;
    vec_t                  step;
    logic signed [X_W-1:0] xs, ys;
    logic signed [Z_W-1:0] dz;

    if (g == 0) begin : g_first
      assign src   = in_data;
      assign src_v = in_valid;
    end else begin : g_next
      assign src   = stg[g-1];
      assign src_v = vld[g-1];
    end

    // Advance when empty or when the next stage advances
    assign rdy[g] = !vld[g] || rdy[g+1];

    // Rotate toward zero residual angle
    always_comb begin
      xs        = src.x >>> g;
      ys        = src.y >>> g;
      dz        = Z_W'(ATAN_TAB[g]);
      step.side = src.side;
      if (!src.z[Z_W-1]) begin
        step.x = src.x - ys;
        step.y = src.y + xs;
        step.z = src.z - dz;
      end else begin
        step.x = src.x + ys;
        step.y = src.y - xs;
        step.z = src.z + dz;
      end
    end

    // Hold or load the stage
    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        stg[g] <= step;
      end
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (rdy[g]) begin
        vld[g] <= src_v;
      end
    end
  end

  assign out_valid = vld[CORDIC_STAGES-1];
  assign out_data  = stg[CORDIC_STAGES-1];

  // First micro-rotation leaves the residual within a quarter turn
  a_first_step: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> ((stg[0].z <= Z_W'(ANG_QTR)) && (stg[0].z >= -Z_W'(ANG_QTR))))
    else $error("residual angle grew in the first micro-rotation");

endmodule

>>> rtl/prc_post.sv
// ----------------------------------------------------------------------------
// prc_post: output rounding and saturation
// Two stages: round off the guard bits and add the center, then clamp.
// ----------------------------------------------------------------------------
module prc_post (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  prc_pkg::vec_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output prc_pkg::res_t out_data
);
  import prc_pkg::*;

  localparam logic signed [X_W-1:0]   HALF   = X_W'(2 ** (FRAC_BITS - 1));
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'({1'b0, {(COORD_W - 1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  logic                      va, vb;
  logic                      rdya, rdyb;
  logic signed [SUM_W-1:0]   sum_x, sum_y;
  logic signed [COORD_W-1:0] bz_a;
  res_t                      res;

  logic signed [X_W-1:0]     xh, yh;
  logic signed [SUM_W-1:0]   sum_x_next, sum_y_next;
  res_t                      res_next;

  assign rdyb     = !vb || out_ready;
  assign rdya     = !va || rdyb;
  assign in_ready = rdya;

  // Round half up to the coordinate LSB and add the center back
  always_comb begin
    xh         = (in_data.x + HALF) >>> FRAC_BITS;
    yh         = (in_data.y + HALF) >>> FRAC_BITS;
    sum_x_next = SUM_W'(xh) + SUM_W'($signed(in_data.side.cx));
    sum_y_next = SUM_W'(yh) + SUM_W'($signed(in_data.side.cy));
  end

  // Clamp to the signed coordinate range and flag it
  always_comb begin
    res_next.overflow = 1'b0;
    res_next.out_z    = bz_a;
    if (sum_x > SAT_HI) begin
      res_next.out_x    = SAT_HI[COORD_W-1:0];
      res_next.overflow = 1'b1;
    end else if (sum_x < SAT_LO) begin
      res_next.out_x    = SAT_LO[COORD_W-1:0];
      res_next.overflow = 1'b1;
    end else begin
      res_next.out_x    = sum_x[COORD_W-1:0];
    end
    if (sum_y > SAT_HI) begin
      res_next.out_y    = SAT_HI[COORD_W-1:0];
      res_next.overflow = 1'b1;
    end else if (sum_y < SAT_LO) begin
      res_next.out_y    = SAT_LO[COORD_W-1:0];
      res_next.overflow = 1'b1;
    end else begin
      res_next.out_y    = sum_y[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (rdya) va <= in_valid;
      if (rdyb) vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rdya) begin
      sum_x <= sum_x_next;
      sum_y <= sum_y_next;
      bz_a  <= in_data.side.bz;
    end
    if (rdyb) begin
      res <= res_next;
    end
  end

  assign out_valid = vb;
  assign out_data  = res;

  // A flagged item sits on a range bound in x or y
  a_ovf_bound: assert property (@(posedge clk) disable iff (rst)
    (vb && res.overflow) |->
      ((res.out_x == SAT_HI[COORD_W-1:0]) || (res.out_x == SAT_LO[COORD_W-1:0]) ||
       (res.out_y == SAT_HI[COORD_W-1:0]) || (res.out_y == SAT_LO[COORD_W-1:0])))
    else $error("overflow flagged without a clamped coordinate");

  // An in-range sum moves on unflagged
  a_no_false_ovf: assert property (@(posedge clk) disable iff (rst)
    (va && rdyb && (sum_x <= SAT_HI) && (sum_x >= SAT_LO) &&
     (sum_y <= SAT_HI) && (sum_y >= SAT_LO)) |=> !res.overflow)
    else $error("overflow flagged for an in-range item");

endmodule

>>> sim/point_rotate_about_center_checker.sv
// ----------------------------------------------------------------------------
// point_rotate_about_center_checker: scoreboard for the point rotation unit
// Watches both channels, computes the rotated point for every accepted input
// item with a 64-bit integer version of the CORDIC datapath, and compares each
// result item field by field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module point_rotate_about_center_checker (
  input  logic clk,
  input  logic rst,
  prc_in_if    points,
  prc_out_if   results,
  output int   fails,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import prc_pkg::*;

  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam longint QUARTER   = longint'(ANG_QTR);
  localparam longint HALF_BAM  = 64'sh80000000;
  localparam longint FULL_BAM  = 64'sh100000000;

  res_t rotated_points_q [$];
  res_t want;
  res_t got;
  point_t taken;

  // Round half up, then shift right with floor
  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Rotate one point about its center as the datapath does
  function automatic res_t rotated_point(point_t pt);
    longint bx, by, cx, cy, ang, turns, x, y, z, swap, xs, ys, ox, oy;
    res_t r;
    bx  = longint'(pt.base_x);
    by  = longint'(pt.base_y);
    cx  = longint'(pt.center_x);
    cy  = longint'(pt.center_y);
    ang = longint'(pt.angle_deg);

    // Reduce to one turn, convert to binary angle, view as signed
    turns = ang % ANG_TURN;
    if (turns < 0) turns += ANG_TURN;
    z = ((turns <<< 32) + ANG_TURN / 2) / ANG_TURN;
    z = z & 64'hFFFFFFFF;
    if (z >= HALF_BAM) z -= FULL_BAM;

    // Prescale offsets by the inverse CORDIC gain
    x = round_shift((bx - cx) * longint'(GAIN_INV), K_W - FRAC_BITS);
    y = round_shift((by - cy) * longint'(GAIN_INV), K_W - FRAC_BITS);

    // Fold angles beyond a quarter turn with an exact swap
    if (z > QUARTER) begin
      swap = x; x = -y; y = swap;
      z -= QUARTER;
    end else if (z < -QUARTER) begin
      swap = x; x = y; y = -swap;
      z += QUARTER;
    end

    // Micro-rotations
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> (i & 31);
      ys = y >>> (i & 31);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN_TAB[i & 31]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN_TAB[i & 31]);
      end
    end

    // Back to coordinate LSB, add center, clamp
    ox = round_shift(x, FRAC_BITS) + cx;
    oy = round_shift(y, FRAC_BITS) + cy;
    r.overflow = 1'b0;
    if (ox > COORD_MAX) begin ox = COORD_MAX; r.overflow = 1'b1; end
    if (ox < COORD_MIN) begin ox = COORD_MIN; r.overflow = 1'b1; end
    if (oy > COORD_MAX) begin oy = COORD_MAX; r.overflow = 1'b1; end
    if (oy < COORD_MIN) begin oy = COORD_MIN; r.overflow = 1'b1; end
    r.out_x = ox[31:0];
    r.out_y = oy[31:0];
    r.out_z = pt.base_z;
    return r;
  endfunction

  // Check results first, then record the item accepted on this edge
  always @(posedge clk) begin
    int errs;
    errs = 0;
    if (rst) begin
      fails   <= 0;
      pending <= 0;
    end else begin
      if (results.valid && results.ready) begin
        got.out_x    = results.out_x;
        got.out_y    = results.out_y;
        got.out_z    = results.out_z;
        got.overflow = results.overflow;
        if (rotated_points_q.size() == 0) begin
          $error("result item with no input item outstanding");
          errs++;
        end else begin
          want = rotated_points_q.pop_front();
          if (got.out_x !== want.out_x) begin
            $error("out_x: expected %0d, actual %0d", want.out_x, got.out_x);
            errs++;
          end
          if (got.out_y !== want.out_y) begin
            $error("out_y: expected %0d, actual %0d", want.out_y, got.out_y);
            errs++;
          end
          if (got.out_z !== want.out_z) begin
            $error("out_z: expected %0d, actual %0d", want.out_z, got.out_z);
            errs++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, got.overflow);
            errs++;
          end
        end
      end
      if (points.valid && points.ready) begin
        taken.base_x    = points.base_x;
        taken.base_y    = points.base_y;
        taken.base_z    = points.base_z;
        taken.center_x  = points.center_x;
        taken.center_y  = points.center_y;
        taken.angle_deg = points.angle_deg;
        rotated_points_q.push_back(rotated_point(taken));
      end
      fails   <= fails + errs;
      pending <= rotated_points_q.size();
    end
  end

endmodule

>>> sim/point_rotate_about_center_unit_test.sv
// ----------------------------------------------------------------------------
// point_rotate_about_center_unit_test: top-level bench for the rotation unit
// Drives directed corner points and a random stream through the input channel
// with random gaps and output stalls; the checker beside the unit predicts
// and compares every result item.
// ----------------------------------------------------------------------------
module point_rotate_about_center_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import prc_pkg::*;

  typedef enum int {NEAR_ORIGIN, FULL_RANGE, NEAR_LIMIT} coord_range_e;

  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFFFFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh80000000;
  localparam logic signed [COORD_W-1:0] C_ONE = 32'sh00010000;
  localparam logic signed [COORD_W-1:0] C_NEG = 32'shFFFFFFFF;

  localparam logic signed [ANG_W-1:0] A_EIGHTH  = 16'sd2880;
  localparam logic signed [ANG_W-1:0] A_QUARTER = 16'sd5760;
  localparam logic signed [ANG_W-1:0] A_HALF    = 16'sd11520;
  localparam logic signed [ANG_W-1:0] A_THREEQ  = 16'sd17280;
  localparam logic signed [ANG_W-1:0] A_TURN    = 16'sd23040;
  localparam logic signed [ANG_W-1:0] A_MAX     = 16'sh7FFF;
  localparam logic signed [ANG_W-1:0] A_MIN     = 16'sh8000;

  localparam int RANDOM_ITEMS = 550;
  localparam int SETTLE_CYCLES = 40;

  logic clk;
  logic rst;
  bit   calm;
  int   fails;
  int   pending;

  prc_in_if  points_ch();
  prc_out_if results_ch();

  point_rotate_about_center_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .points  (points_ch),
    .results (results_ch)
  );

  point_rotate_about_center_checker scoreboard (
    .clk     (clk),
    .rst     (rst),
    .points  (points_ch),
    .results (results_ch),
    .fails   (fails),
    .pending (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Abort a hung run
  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic point_t make_point(
    logic signed [COORD_W-1:0] bx, logic signed [COORD_W-1:0] by,
    logic signed [COORD_W-1:0] bz, logic signed [COORD_W-1:0] cx,
    logic signed [COORD_W-1:0] cy, logic signed [ANG_W-1:0] ang);
    point_t pt;
    pt.base_x = bx; pt.base_y = by; pt.base_z = bz;
    pt.center_x = cx; pt.center_y = cy; pt.angle_deg = ang;
    return pt;
  endfunction

  // Mostly short gaps, a few long ones, none in calm stretches
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord(coord_range_e span);
    case (span)
      NEAR_ORIGIN: begin
        return int'($urandom_range(0, 33554431)) - 16777216;
      end
      NEAR_LIMIT: begin
        if ($urandom_range(0, 1)) return C_MAX - $urandom_range(0, 4095);
        return C_MIN + $urandom_range(0, 4095);
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  function automatic logic signed [ANG_W-1:0] rand_angle();
    int quads;
    if ($urandom_range(0, 9) < 6) return ANG_W'($urandom);
    quads = int'($urandom_range(0, 10)) - 5;
    return ANG_W'(quads * A_QUARTER + int'($urandom_range(0, 4)) - 2);
  endfunction

  function automatic point_t rand_point();
    point_t pt;
    int pick;
    coord_range_e span;
    pick = $urandom_range(0, 99);
    span = (pick < 50) ? NEAR_ORIGIN : (pick < 80) ? FULL_RANGE : NEAR_LIMIT;
    pt.base_x   = rand_coord(span);
    pt.base_y   = rand_coord(span);
    pt.base_z   = $urandom;
    pt.center_x = rand_coord(span == NEAR_LIMIT ? FULL_RANGE : span);
    pt.center_y = rand_coord(span == NEAR_LIMIT ? FULL_RANGE : span);
    pt.angle_deg = rand_angle();
    // Occasionally rotate a point sitting on its center
    if ($urandom_range(0, 19) == 0) begin
      pt.center_x = pt.base_x;
      pt.center_y = pt.base_y;
    end
    return pt;
  endfunction

  // Present one item after an optional gap and hold it until accepted
  task automatic send_point(point_t pt, int gap);
    @(negedge clk);
    if (gap > 0) begin
      points_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    points_ch.valid     <= 1'b1;
    points_ch.base_x    <= pt.base_x;
    points_ch.base_y    <= pt.base_y;
    points_ch.base_z    <= pt.base_z;
    points_ch.center_x  <= pt.center_x;
    points_ch.center_y  <= pt.center_y;
    points_ch.angle_deg <= pt.angle_deg;
    @(posedge clk);
    while (!points_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    points_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: runs of ready broken by stalls of random length
  initial begin
    int run_len;
    int stall_len;
    results_ch.ready = 1'b0;
    forever begin
      run_len = $urandom_range(1, 24);
      repeat (run_len) begin
        @(negedge clk);
        results_ch.ready <= 1'b1;
      end
      stall_len = idle_len();
      repeat (stall_len) begin
        @(negedge clk);
        results_ch.ready <= 1'b0;
      end
    end
  end

  // Stimulus
  initial begin
    rst                 = 1'b1;
    calm                = 1'b0;
    points_ch.valid     = 1'b0;
    points_ch.base_x    = '0;
    points_ch.base_y    = '0;
    points_ch.base_z    = '0;
    points_ch.center_x  = '0;
    points_ch.center_y  = '0;
    points_ch.angle_deg = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: quadrant folds, angle wrap, extremes and saturation
    send_point(make_point('0, '0, '0, '0, '0, '0), idle_len());
    send_point(make_point(C_ONE, '0, C_ONE, '0, '0, A_QUARTER), idle_len());
    send_point(make_point(C_ONE, C_ONE, '0, '0, '0, A_HALF), idle_len());
    send_point(make_point(C_ONE, -C_ONE, C_NEG, '0, '0, -A_QUARTER), idle_len());
    send_point(make_point(C_ONE, '0, '0, C_ONE, C_ONE, A_THREEQ), idle_len());
    send_point(make_point(C_ONE, C_ONE, '0, '0, '0, A_QUARTER + 16'sd1), idle_len());
    send_point(make_point(C_ONE, C_ONE, '0, '0, '0, -A_QUARTER - 16'sd1), idle_len());
    send_point(make_point(C_ONE, C_ONE, '0, '0, '0, A_MAX), idle_len());
    send_point(make_point(C_ONE, C_ONE, '0, '0, '0, A_MIN), idle_len());
    send_point(make_point(C_ONE, C_ONE, '0, '0, '0, A_TURN), idle_len());
    send_point(make_point(C_ONE, C_ONE, '0, '0, '0, -A_TURN), idle_len());
    send_point(make_point(C_ONE, C_ONE, '0, '0, '0, 16'sd1), idle_len());
    send_point(make_point(C_ONE, C_ONE, '0, '0, '0, -16'sd1), idle_len());
    send_point(make_point(C_ONE, C_ONE, '0, '0, '0, A_HALF + 16'sd1), idle_len());
    send_point(make_point(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, '0), idle_len());
    send_point(make_point(C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, A_HALF), idle_len());
    send_point(make_point(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, A_HALF), idle_len());
    send_point(make_point(C_MAX, C_MAX, '0, '0, '0, A_EIGHTH), idle_len());
    send_point(make_point(C_MIN, C_MIN, '0, '0, '0, A_EIGHTH), idle_len());
    send_point(make_point(C_MIN, C_MIN, C_NEG, C_MAX, C_MAX, A_QUARTER), idle_len());
    send_point(make_point(C_MAX, C_MIN, '0, C_MIN, C_MAX, -A_QUARTER), idle_len());
    send_point(make_point(C_NEG, C_NEG, C_NEG, C_NEG, C_NEG, A_MAX), idle_len());
    send_point(make_point(C_MAX, '0, '0, C_MAX, '0, A_HALF), idle_len());
    drain();

    // Random stream with calm stretches and periodic full drains
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = ((n / 40) % 3 == 1);
      if (n % 150 == 149) drain();
      send_point(rand_point(), idle_len());
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
